### rtl/core/ssr_pkg.sv
package ssr_pkg;

   // Field widths
   localparam int CFG_W     = 16;
   localparam int CMD_W     = 2;
   localparam int AXIS_W    = 2;
   localparam int DELAY_W   = 12;
   localparam int OUT_POS_W = 32;
   localparam int PHASE_W   = 32;
   localparam int PROF_W    = 2;

   // Storage sizes
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int POSITION_WIDTH   = 32;
   localparam int STEP_COUNT_WIDTH = 16;
   localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
   localparam int SINE_W           = 15;
   localparam int PROD_W           = DELAY_W + SINE_W;
   localparam int NUM_AXES         = 3;

   // Reciprocal divider: 2^PHASE_W / (n + 1), one quotient bit per cycle
   localparam int DIV_STEPS = PHASE_W + 1;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [63:0] STEP_CNT_MAX = (64'd1 << STEP_COUNT_WIDTH) - 64'd1;
   localparam logic [CFG_W-1:0] CFG_RESET = 16'd500;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_START = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // Axis codes
   localparam logic [AXIS_W-1:0] AXIS_X     = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y     = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_THETA = 2'd2;

   // Delay profile codes and move length limits
   localparam logic [PROF_W-1:0] PROF_FLAT  = 2'd0;
   localparam logic [PROF_W-1:0] PROF_MID   = 2'd1;
   localparam logic [PROF_W-1:0] PROF_STEEP = 2'd2;
   localparam logic [31:0] FLAT_LIMIT = 32'd100;
   localparam logic [31:0] MID_LIMIT  = 32'd300;

   // Delay sets in microseconds, indexed by profile
   localparam logic [DELAY_W-1:0] DLY_MAX [4] = '{12'd2000, 12'd2500, 12'd3000, 12'd3000};
   localparam logic [DELAY_W-1:0] DLY_MIN [4] = '{12'd2000, 12'd1200, 12'd800, 12'd800};
   localparam logic [DELAY_W-1:0] DLY_FLOOR [4] = '{12'd2000, 12'd1000, 12'd800, 12'd800};

   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   typedef struct packed {
      logic capture;
      logic div_start;
      logic div_step;
      logic commit;
   } ssr_cmd_type;

   typedef struct packed {
      logic start_ok;
      logic div_done;
   } ssr_status_type;

   // Half-wave sine entry in Q0.15, Taylor series through x^13 in Q30.
   // Called with constant arguments only, to build the lookup table.
   function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
      logic [63:0]        kk;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        q;
      logic signed [63:0] sum;
      kk = (k <= SINE_TABLE_DEPTH - k) ? 64'(k) : 64'(SINE_TABLE_DEPTH - k);
      x = (PI_Q30 * kk) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = signed'(x);
      for (int n = 1; n <= 6; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if ((n % 2) == 1) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      q = (64'(sum) + 64'd16384) >> 15;
      if (q > 64'd32767) begin
         q = 64'd32767;
      end
      return q[SINE_W-1:0];
   endfunction

endpackage

### rtl/core/ssr_req_if.sv
interface ssr_req_if import ssr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [AXIS_W-1:0] axis;
   logic              direction;
   logic              limit_hit;

   modport source (output valid, output cmd, output axis, output direction,
                   output limit_hit, input ready);
   modport sink (input valid, input cmd, input axis, input direction,
                 input limit_hit, output ready);
endinterface

### rtl/core/ssr_rsp_if.sv
interface ssr_rsp_if import ssr_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic                        step_pulse;
   logic [DELAY_W-1:0]          half_period_us;
   logic                        dir_level;
   logic                        move_done;
   logic                        aborted;
   logic signed [OUT_POS_W-1:0] pos_x;
   logic signed [OUT_POS_W-1:0] pos_y;
   logic signed [OUT_POS_W-1:0] pos_theta;

   modport source (output valid, output step_pulse, output half_period_us,
                   output dir_level, output move_done, output aborted,
                   output pos_x, output pos_y, output pos_theta, input ready);
   modport sink (input valid, input step_pulse, input half_period_us,
                 input dir_level, input move_done, input aborted,
                 input pos_x, input pos_y, input pos_theta, output ready);
endinterface

### rtl/core/stepper_sine_ramp_stepper.sv
// Three-axis stepper move sequencer with a sine-shaped speed ramp.
//
// req_channel carries one command transaction: start a move (axis and
// direction), one step slot (with the watched limit switch level), or a
// clear of all three position counters. rsp_channel returns exactly one
// result transaction per request: step pulse flag, half-period in us,
// direction level, move done, aborted, and the three position counts.
// csr_write_enable / csr_write_data load steps_per_move, latched by the
// next start; write it only while no transaction is in flight.
//
// Sequencing: a step, clear, unused command or start on the spare axis
// passes from accept through sine table lookup, delay-span multiply, then
// commit. A start on a valid axis passes through lookup, then the
// reciprocal divider that forms the phase increment 2^32/(N+1) one bit per
// cycle, then commit. One transaction is in flight at a time.
//
// Reset (synchronous, active high) clears the move state and positions and
// sets steps_per_move to 500. A result waiting on rsp_channel does not
// block the next request; a finished result holds until the receiver takes
// the previous one.
module stepper_sine_ramp_stepper import ssr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   ssr_req_if.sink          req_channel,
   ssr_rsp_if.source        rsp_channel,
   input  logic             csr_write_enable,
   input  logic [CFG_W-1:0] csr_write_data
);

   ssr_cmd_type    ctrl_cmd;
   ssr_status_type dp_status;

   // Sequence each transaction through lookup, scale/divide and commit
   ssr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .rsp_valid (rsp_channel.valid),
      .rsp_ready (rsp_channel.ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // Hold move state, positions, sine table, divider and result register
   ssr_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_cmd            (req_channel.cmd),
      .req_axis           (req_channel.axis),
      .req_direction      (req_channel.direction),
      .req_limit_hit      (req_channel.limit_hit),
      .ctrl               (ctrl_cmd),
      .status             (dp_status),
      .rsp_step_pulse     (rsp_channel.step_pulse),
      .rsp_half_period_us (rsp_channel.half_period_us),
      .rsp_dir_level      (rsp_channel.dir_level),
      .rsp_move_done      (rsp_channel.move_done),
      .rsp_aborted        (rsp_channel.aborted),
      .rsp_pos_x          (rsp_channel.pos_x),
      .rsp_pos_y          (rsp_channel.pos_y),
      .rsp_pos_theta      (rsp_channel.pos_theta)
   );

endmodule

### rtl/core/ssr_ctrl.sv
module ssr_ctrl import ssr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  ssr_status_type status,
   output ssr_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOKUP = 3'd1;
   localparam logic [2:0] S_SCALE  = 3'd2;
   localparam logic [2:0] S_DIVIDE = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;
   logic       slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.capture   = accept;
   assign cmd.div_start = (state_ff == S_LOOKUP);
   assign cmd.div_step  = (state_ff == S_DIVIDE);
   assign cmd.commit    = (state_ff == S_EMIT) && slot_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = status.start_ok ? S_DIVIDE : S_SCALE;
         end
         S_SCALE: begin
            state_in = S_EMIT;
         end
         S_DIVIDE: begin
            if (status.div_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LOOKUP))
      else $error("accepted transaction did not enter lookup");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE && status.div_done) |=> (state_ff == S_EMIT))
      else $error("divider finished but result not emitted");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == S_EMIT && rsp_valid_ff))
      else $error("result emitted over a stalled transaction");

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("commit did not present a result");

endmodule

### rtl/core/ssr_datapath.sv
module ssr_datapath import ssr_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [CFG_W-1:0]            csr_write_data,
   input  logic [CMD_W-1:0]            req_cmd,
   input  logic [AXIS_W-1:0]           req_axis,
   input  logic                        req_direction,
   input  logic                        req_limit_hit,
   input  ssr_cmd_type                 ctrl,
   output ssr_status_type              status,
   output logic                        rsp_step_pulse,
   output logic [DELAY_W-1:0]          rsp_half_period_us,
   output logic                        rsp_dir_level,
   output logic                        rsp_move_done,
   output logic                        rsp_aborted,
   output logic signed [OUT_POS_W-1:0] rsp_pos_x,
   output logic signed [OUT_POS_W-1:0] rsp_pos_y,
   output logic signed [OUT_POS_W-1:0] rsp_pos_theta
);

   // Configuration
   logic [CFG_W-1:0] spm_ff;

   // Latched transaction
   logic [CMD_W-1:0]  cmd_ff;
   logic [AXIS_W-1:0] axis_ff;
   logic              dir_ff;
   logic              limit_ff;

   // Move state
   logic                        active_ff, active_in;
   logic [AXIS_W-1:0]           act_axis_ff, act_axis_in;
   logic                        act_dir_ff, act_dir_in;
   logic [STEP_COUNT_WIDTH-1:0] index_ff, index_in;
   logic [STEP_COUNT_WIDTH-1:0] length_ff, length_in;
   logic [PHASE_W-1:0]          inc_ff, inc_in;
   logic [PHASE_W-1:0]          acc_ff, acc_in;
   logic [PROF_W-1:0]           prof_ff, prof_in;
   logic [POSITION_WIDTH-1:0]   pos_ff [NUM_AXES];
   logic [POSITION_WIDTH-1:0]   pos_in [NUM_AXES];

   // Ramp pipeline
   logic [SINE_W-1:0] sine_rom [SINE_TABLE_DEPTH];
   logic [PHASE_W+SINE_IDX_W-1:0] phase_scaled;
   logic [SINE_IDX_W-1:0]         sine_idx;
   logic [SINE_W-1:0]             sine_ff;
   logic [PROD_W-1:0]             prod_ff;
   logic [DELAY_W-1:0]            span;
   logic [DELAY_W-1:0]            ramp_delay;
   logic [DELAY_W-1:0]            delay;

   // Reciprocal divider
   logic [STEP_COUNT_WIDTH-1:0] n_sat;
   logic [STEP_COUNT_WIDTH:0]   divisor;
   logic [STEP_COUNT_WIDTH-1:0] rem_ff;
   logic [STEP_COUNT_WIDTH:0]   trial;
   logic                        q_bit;
   logic [PHASE_W-1:0]          quo_ff;
   logic [DIV_CNT_W-1:0]        cnt_ff;

   // Result
   logic                        pulse, aborted;
   logic [DELAY_W-1:0]          half;
   logic [STEP_COUNT_WIDTH-1:0] index_next;
   logic [AXIS_W-1:0]           step_axis;

   for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
      localparam logic [SINE_W-1:0] ENTRY = sine_entry(k);
      assign sine_rom[k] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spm_ff <= CFG_RESET;
      end else if (csr_write_enable) begin
         spm_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff   <= req_cmd;
         axis_ff  <= req_axis;
         dir_ff   <= req_direction;
         limit_ff <= req_limit_hit;
      end
   end

   // Lookup then scale; both registered, consumed at commit
   assign phase_scaled = (PHASE_W + SINE_IDX_W)'(acc_ff)
                         * (PHASE_W + SINE_IDX_W)'(SINE_TABLE_DEPTH);
   assign sine_idx     = phase_scaled[PHASE_W+SINE_IDX_W-1 -: SINE_IDX_W];
   assign span         = DLY_MAX[prof_ff] - DLY_MIN[prof_ff];

   always_ff @(posedge clock) begin
      sine_ff <= sine_rom[sine_idx];
      prod_ff <= PROD_W'(span) * PROD_W'(sine_ff);
   end

   always_comb begin
      ramp_delay = DLY_MAX[prof_ff] - prod_ff[PROD_W-1 -: DELAY_W];
      if (ramp_delay < DLY_FLOOR[prof_ff]) begin
         ramp_delay = DLY_FLOOR[prof_ff];
      end
      if (32'(length_ff) <= FLAT_LIMIT) begin
         delay = DLY_MAX[prof_ff];
      end else begin
         delay = ramp_delay;
      end
   end

   // Divider: restoring, dividend 2^PHASE_W, MSB first
   assign n_sat   = (64'(spm_ff) > STEP_CNT_MAX) ? STEP_COUNT_WIDTH'(STEP_CNT_MAX)
                                                 : STEP_COUNT_WIDTH'(spm_ff);
   assign divisor = (STEP_COUNT_WIDTH + 1)'(n_sat) + 1'b1;
   assign trial   = {rem_ff, (cnt_ff == DIV_CNT_W'(PHASE_W))};
   assign q_bit   = (trial >= divisor);

   always_ff @(posedge clock) begin
      if (ctrl.div_start) begin
         rem_ff <= '0;
         quo_ff <= '0;
         cnt_ff <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (ctrl.div_step) begin
         rem_ff <= q_bit ? STEP_COUNT_WIDTH'(trial - divisor) : STEP_COUNT_WIDTH'(trial);
         quo_ff <= {quo_ff[PHASE_W-2:0], q_bit};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign status.start_ok = (cmd_ff == CMD_START) && (axis_ff <= AXIS_THETA);
   assign status.div_done = (cnt_ff == '0);

   assign index_next = index_ff + 1'b1;
   assign step_axis  = (act_axis_ff > AXIS_THETA) ? AXIS_THETA : act_axis_ff;

   always_comb begin
      active_in   = active_ff;
      act_axis_in = act_axis_ff;
      act_dir_in  = act_dir_ff;
      index_in    = index_ff;
      length_in   = length_ff;
      inc_in      = inc_ff;
      acc_in      = acc_ff;
      prof_in     = prof_ff;
      pos_in      = pos_ff;
      pulse       = 1'b0;
      aborted     = 1'b0;
      half        = '0;
      case (cmd_ff)
         CMD_START: begin
            if (axis_ff <= AXIS_THETA) begin
               length_in   = n_sat;
               act_axis_in = axis_ff;
               act_dir_in  = dir_ff;
               index_in    = '0;
               acc_in      = '0;
               inc_in      = quo_ff;
               if (32'(n_sat) <= FLAT_LIMIT) begin
                  prof_in = PROF_FLAT;
               end else if (32'(n_sat) <= MID_LIMIT) begin
                  prof_in = PROF_MID;
               end else begin
                  prof_in = PROF_STEEP;
               end
               active_in = (n_sat != '0);
            end
         end
         CMD_STEP: begin
            if (active_ff) begin
               if (limit_ff) begin
                  active_in = 1'b0;
                  aborted   = 1'b1;
               end else begin
                  half  = delay;
                  pulse = 1'b1;
                  for (int j = 0; j < NUM_AXES; j++) begin
                     if (step_axis == AXIS_W'(j)) begin
                        pos_in[j] = act_dir_ff ? pos_ff[j] + 1'b1 : pos_ff[j] - 1'b1;
                     end
                  end
                  index_in = index_next;
                  acc_in   = acc_ff + inc_ff;
                  if (index_next >= length_ff) begin
                     active_in = 1'b0;
                  end
               end
            end
         end
         CMD_CLEAR: begin
            for (int j = 0; j < NUM_AXES; j++) begin
               pos_in[j] = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         act_axis_ff <= AXIS_X;
         act_dir_ff  <= 1'b0;
         index_ff    <= '0;
         length_ff   <= '0;
         inc_ff      <= '0;
         acc_ff      <= '0;
         prof_ff     <= PROF_FLAT;
         for (int j = 0; j < NUM_AXES; j++) begin
            pos_ff[j] <= '0;
         end
      end else if (ctrl.commit) begin
         active_ff   <= active_in;
         act_axis_ff <= act_axis_in;
         act_dir_ff  <= act_dir_in;
         index_ff    <= index_in;
         length_ff   <= length_in;
         inc_ff      <= inc_in;
         acc_ff      <= acc_in;
         prof_ff     <= prof_in;
         pos_ff      <= pos_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         rsp_step_pulse     <= pulse;
         rsp_half_period_us <= half;
         rsp_dir_level      <= act_dir_in;
         rsp_move_done      <= !active_in;
         rsp_aborted        <= aborted;
         rsp_pos_x          <= OUT_POS_W'(signed'(pos_in[0]));
         rsp_pos_y          <= OUT_POS_W'(signed'(pos_in[1]));
         rsp_pos_theta      <= OUT_POS_W'(signed'(pos_in[2]));
      end
   end

endmodule
